// ----- sv/crc32_lsb_first_byte_update_assert.svh -----
// assertion macros shared by the crc32 byte update rtl
`ifndef CRC32_LSB_FIRST_BYTE_UPDATE_ASSERT_SVH
`define CRC32_LSB_FIRST_BYTE_UPDATE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CRC32LU_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("crc32lu same-cycle check failed");

// next-cycle implication, checked outside reset
`define CRC32LU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("crc32lu next-cycle check failed");

`endif

// ----- sv/crc32lu_pkg.sv -----
// shared types and constants for the crc32 byte update block
`default_nettype none
package crc32lu_pkg;

	localparam int unsigned CRC_W  = 32;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned ADDR_W = 4;
	localparam int unsigned IDX_W  = 2;

	// register index codes, byte address is 4 * index
	localparam logic [IDX_W-1:0] REG_POLYNOMIAL    = 2'd0;
	localparam logic [IDX_W-1:0] REG_INITIAL_VALUE = 2'd1;
	localparam logic [IDX_W-1:0] REG_FINAL_MASK    = 2'd2;

	localparam logic [CRC_W-1:0] RST_POLYNOMIAL    = 32'h04C1_1DB7;
	localparam logic [CRC_W-1:0] RST_INITIAL_VALUE = 32'hFFFF_FFFF;
	localparam logic [CRC_W-1:0] RST_FINAL_MASK    = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [CRC_W-1:0] polynomial;
		logic [CRC_W-1:0] initial_value;
		logic [CRC_W-1:0] final_mask;
	} cfg_t;

endpackage
`default_nettype wire

// ----- sv/crc32lu_cfg_regs.sv -----
// apb-style configuration registers for the crc32 byte update block
`default_nettype none
module crc32lu_cfg_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [crc32lu_pkg::ADDR_W-1:0] paddr,
	input  wire logic [crc32lu_pkg::DATA_W-1:0] pwdata,
	output logic      [crc32lu_pkg::DATA_W-1:0] prdata,
	output logic                             pready,
	output crc32lu_pkg::cfg_t                cfg
);
	import crc32lu_pkg::*;

	cfg_t             cfg_q;
	logic             wr_en;
	logic [IDX_W-1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	// word index, byte offset bits ignored
	assign reg_idx = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.polynomial    <= RST_POLYNOMIAL;
			cfg_q.initial_value <= RST_INITIAL_VALUE;
			cfg_q.final_mask    <= RST_FINAL_MASK;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_POLYNOMIAL:    cfg_q.polynomial    <= pwdata;
				REG_INITIAL_VALUE: cfg_q.initial_value <= pwdata;
				REG_FINAL_MASK:    cfg_q.final_mask    <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_POLYNOMIAL:    prdata = cfg_q.polynomial;
			REG_INITIAL_VALUE: prdata = cfg_q.initial_value;
			REG_FINAL_MASK:    prdata = cfg_q.final_mask;
			default:           prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ----- sv/crc32lu_byte_engine.sv -----
// eight unrolled lsb-first shift and xor steps over one byte
`default_nettype none
module crc32lu_byte_engine (
	input  wire logic [crc32lu_pkg::CRC_W-1:0]  crc_in,
	input  wire logic [crc32lu_pkg::BYTE_W-1:0] data,
	input  wire logic [crc32lu_pkg::CRC_W-1:0]  polynomial,
	output logic      [crc32lu_pkg::CRC_W-1:0]  crc_out
);
	import crc32lu_pkg::*;

	always_comb begin
		logic [CRC_W-1:0] r;
		logic             fb;
		r = crc_in;
		for (int k = 0; k < BYTE_W; k++) begin
			fb = r[0] ^ data[k];
			r  = {1'b0, r[CRC_W-1:1]};
			if (fb) begin
				r = r ^ polynomial;
			end
		end
		crc_out = r;
	end

endmodule
`default_nettype wire

// ----- sv/crc32_lsb_first_byte_update.sv -----
// top level of the crc32 byte update block
//
// bytewise crc engine, one message byte per request, bits taken least
// significant first; each byte shifts the 32-bit running crc right eight times,
// xoring in the polynomial register whenever crc bit 0 xor the data bit is one.
// start_new reloads initial_value before the byte; every request yields one
// result, crc_value = running crc xor final_mask, with is_final copying
// last_byte. the reset polynomial 0x04C11DB7 is taken as given with the right
// shift; write 0xEDB88320 for standard crc-32. throughput is one byte per
// clock while crc_stall is low: a request sits in the input stage while the
// eight unrolled steps form its crc, then moves to the result register, which
// drives crc_valid. the running crc is updated as the request leaves the
// input stage, which closes the byte-to-byte loop. the result register and the
// input stage are separate, so a new byte is taken into an empty input stage
// while an earlier result waits; stalls ripple back through byte_stall in the
// same cycle. registers sit at byte addresses 0, 4 and 8 and should be written
// only while no request is in flight.
`default_nettype none
module crc32_lsb_first_byte_update (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// configuration port
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [crc32lu_pkg::ADDR_W-1:0] paddr,
	input  wire logic [crc32lu_pkg::DATA_W-1:0] pwdata,
	output logic      [crc32lu_pkg::DATA_W-1:0] prdata,
	output logic                                pready,
	// byte requests
	input  wire logic                           byte_valid,
	output logic                                byte_stall,
	input  wire logic [crc32lu_pkg::BYTE_W-1:0] data_byte,
	input  wire logic                           start_new,
	input  wire logic                           last_byte,
	// crc results
	output logic                                crc_valid,
	input  wire logic                           crc_stall,
	output logic      [crc32lu_pkg::CRC_W-1:0]  crc_value,
	output logic                                is_final
);
	import crc32lu_pkg::*;

	`include "crc32_lsb_first_byte_update_assert.svh"

	cfg_t cfg;

	// input stage
	logic              valid_s1;
	logic [BYTE_W-1:0] data_byte_s1;
	logic              start_new_s1;
	logic              last_byte_s1;

	// result stage
	logic              valid_s2;
	logic [CRC_W-1:0]  crc_value_s2;
	logic              is_final_s2;

	// running crc carried from byte to byte
	logic [CRC_W-1:0]  running_crc_q;

	logic              load_s2;
	logic              adv_s1;
	logic              load_s1;
	logic [CRC_W-1:0]  seed;
	logic [CRC_W-1:0]  crc_next;

	crc32lu_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// result register frees when empty or being taken this cycle
	assign load_s2    = !valid_s2 || !crc_stall;
	assign adv_s1     = valid_s1 && load_s2;
	assign load_s1    = !valid_s1 || load_s2;
	assign byte_stall = !load_s1;

	// start of message seeds from the initial value register
	assign seed = start_new_s1 ? cfg.initial_value : running_crc_q;

	crc32lu_byte_engine u_byte_engine (
		.crc_in     (seed),
		.data       (data_byte_s1),
		.polynomial (cfg.polynomial),
		.crc_out    (crc_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && byte_valid) begin
			data_byte_s1 <= data_byte;
			start_new_s1 <= start_new;
			last_byte_s1 <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2      <= 1'b0;
			running_crc_q <= RST_INITIAL_VALUE;
		end else begin
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s1) begin
				running_crc_q <= crc_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			crc_value_s2 <= crc_next ^ cfg.final_mask;
			is_final_s2  <= last_byte_s1;
		end
	end

	assign crc_valid = valid_s2;
	assign crc_value = crc_value_s2;
	assign is_final  = is_final_s2;

	// stall only ever comes from a held input stage
	`CRC32LU_ASSERT_IMPLY(a_stall_needs_s1, clk, arst_n, byte_stall, valid_s1)
	// an accepted byte always lands in the input stage
	`CRC32LU_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, byte_valid && !byte_stall, valid_s1)
	// a byte leaving the input stage always shows up as a result
	`CRC32LU_ASSERT_NEXT(a_adv_fills_s2, clk, arst_n, adv_s1, crc_valid)
	// the running crc moves only with a byte
	`CRC32LU_ASSERT_NEXT(a_crc_held, clk, arst_n, !adv_s1, $stable(running_crc_q))
	// last byte mark follows its byte into the result
	`CRC32LU_ASSERT_NEXT(a_final_follows, clk, arst_n, adv_s1 && last_byte_s1, is_final)

endmodule
`default_nettype wire
